// ----- rtl/hft_pkg.sv -----
// ----------------------------------------------------------------------------
// hft_pkg
// shared commands, widths and helpers of the multisize forward transform core
// ----------------------------------------------------------------------------
package hft_pkg;

  localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
  localparam logic [1:0] CMD_LOAD_RES  = 2'd1;
  localparam logic [1:0] CMD_READ_ROW  = 2'd2;

  localparam int unsigned DataW = 16;
  localparam int unsigned AccW  = 32;

  // product of two signed 16-bit values, wraps into 32 bits
  function automatic logic [AccW-1:0] mul16(input logic [DataW-1:0] a,
                                            input logic [DataW-1:0] b);
    logic signed [AccW-1:0] p;
    p = $signed(a) * $signed(b);
    return p;
  endfunction

endpackage

// ----- rtl/hft_ram.sv -----
// ----------------------------------------------------------------------------
// hft_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module hft_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/hevc_forward_transform_multisize_core.sv -----
// ----------------------------------------------------------------------------
// hevc_forward_transform_multisize_core
// two-dimensional forward core transform y = a * b * a^t, 4x4 up to 32x32
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid_i/in_ready_o): one item carries command, position and
//   sample. loads write one element of the transform matrix or of the
//   residual block. a read command computes one row of y and emits it as n
//   items on the out channel (out_valid_o/out_ready_i), column 0 first,
//   row_end_o high on the last one.
//   cfg channel (cfg_valid_i/cfg_ready_o): writes size_log2, only while idle.
// throughput
//   a read walks two dot-product passes over the stores (one read port each,
//   one product per cycle). each stage-one column is issued, drained and
//   rounded into a t row register; each output coefficient is issued, drained
//   and held in the output register until taken. the memory read port sets
//   the pace. loads are accepted every cycle while no read is busy.
// reset
//   control clears; size_log2 returns to 2. store contents are undefined
//   until written and no clearing pass is run.
// stalls
//   each output item sits in an output register; the engine waits for the
//   receiver before computing the next coefficient.
// ----------------------------------------------------------------------------
module hevc_forward_transform_multisize_core #(
  parameter int unsigned MAX_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [9:0]  position_i,
  input  logic signed [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] coeff_out_o,
  output logic [4:0]  column_o,
  output logic        row_end_o
);
  import hft_pkg::*;

  localparam int unsigned Depth = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned MaxLg = (MAX_SIZE >= 32) ? 5 : (MAX_SIZE >= 16) ? 4 :
                                  (MAX_SIZE >= 8) ? 3 : 2;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_S1   = 3'd1;  // stage one, issue reads
  localparam logic [2:0] ST_S1F  = 3'd2;  // stage one, drain and store t
  localparam logic [2:0] ST_S2   = 3'd3;  // stage two, issue reads
  localparam logic [2:0] ST_S2F  = 3'd4;  // stage two, drain, emit
  localparam logic [2:0] ST_OUT  = 3'd5;  // wait for receiver

  logic [2:0] state_q, state_d;
  logic [2:0] lg_cfg_q;
  logic [2:0] lg_q;          // effective log2 size of the current read
  logic [4:0] row_q;
  logic [5:0] k_q;           // outer index (column of t, or j of y)
  logic [5:0] m_q;           // inner index being issued
  logic       v1_q, v2_q;    // read-in-flight, product-in-flight
  logic [AccW-1:0] prod_q, acc_q;
  logic [DataW-1:0] trow_q [32];
  logic [DataW-1:0] tsel_q;
  logic       outv_q;
  logic [DataW-1:0] out_coef_q;
  logic [4:0] out_col_q;
  logic       out_end_q;

  logic [5:0] n;
  assign n = 6'd1 << lg_q;

  // effective log2 of size register
  logic [2:0] lg_eff;
  always_comb begin
    lg_eff = lg_cfg_q;
    if (lg_cfg_q < 3'd2) lg_eff = 3'd2;
    if (lg_cfg_q > 3'(MaxLg)) lg_eff = 3'(MaxLg);
  end

  wire in_acc  = in_valid_i & in_ready_o;
  wire is_load = in_acc & (command_i == CMD_LOAD_COEF || command_i == CMD_LOAD_RES);
  wire pos_ok  = {22'd0, position_i} < 32'(Depth);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  // address generation
  logic [AW-1:0] ta_raddr, ra_raddr;
  logic [10:0]   a_idx, b_idx;
  always_comb begin
    if (state_q == ST_S1) begin
      a_idx = (11'(row_q) << lg_q) + 11'(m_q);
      b_idx = (11'(m_q) << lg_q) + 11'(k_q);
    end else begin
      a_idx = (11'(k_q) << lg_q) + 11'(m_q);
      b_idx = 11'd0;
    end
  end
  assign ta_raddr = a_idx[AW-1:0];
  assign ra_raddr = b_idx[AW-1:0];

  logic [DataW-1:0] ta_rdata, ra_rdata;

  hft_ram #(.Width(DataW), .Depth(Depth)) u_tstore (
    .clk_i, .we_i(is_load & pos_ok & (command_i == CMD_LOAD_COEF)),
    .waddr_i(position_i[AW-1:0]), .wdata_i(sample_i),
    .raddr_i(ta_raddr), .rdata_o(ta_rdata));

  hft_ram #(.Width(DataW), .Depth(Depth)) u_rstore (
    .clk_i, .we_i(is_load & pos_ok & (command_i == CMD_LOAD_RES)),
    .waddr_i(position_i[AW-1:0]), .wdata_i(sample_i),
    .raddr_i(ra_raddr), .rdata_o(ra_rdata));

  // rounding of finished accumulators
  logic [AccW-1:0] r1, r2;
  logic [AccW-1:0] acc_fin;
  assign acc_fin = acc_q + (v2_q ? prod_q : '0);
  assign r1 = AccW'($signed(acc_fin + (32'd1 << (lg_q - 3'd2))) >>> (lg_q - 3'd1));
  assign r2 = AccW'($signed(acc_fin + (32'd1 << (6'(lg_q) + 6'd5))) >>>
                    (6'(lg_q) + 6'd6));

  wire last_m = (m_q == n - 6'd1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && command_i == CMD_READ_ROW &&
                   {1'b0, position_i} < 11'(6'd1 << lg_eff)) state_d = ST_S1;
      ST_S1:   if (last_m) state_d = ST_S1F;
      ST_S1F:  if (!v1_q && !v2_q) state_d = (k_q == n - 6'd1) ? ST_S2 : ST_S1;
      ST_S2:   if (last_m) state_d = ST_S2F;
      ST_S2F:  if (!v1_q && !v2_q) state_d = ST_OUT;
      ST_OUT:  if (!outv_q) state_d = (k_q == n - 6'd1) ? ST_IDLE : ST_S2;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      lg_cfg_q <= 3'd2;
      lg_q     <= 3'd2;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      outv_q   <= 1'b0;
      row_q    <= '0;
      k_q      <= '0;
      m_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) lg_cfg_q <= cfg_data_i;
      if (outv_q && out_ready_i) outv_q <= 1'b0;
      v1_q <= (state_q == ST_S1 || state_q == ST_S2);
      v2_q <= v1_q;
      case (state_q)
        ST_IDLE: begin
          lg_q  <= lg_eff;
          row_q <= position_i[4:0];
          k_q   <= '0;
          m_q   <= '0;
          acc_q <= '0;
        end
        ST_S1, ST_S2: begin
          m_q <= last_m ? '0 : m_q + 6'd1;
          if (v2_q) acc_q <= acc_q + prod_q;
        end
        ST_S1F: begin
          if (v2_q) acc_q <= acc_q + prod_q;
          if (!v1_q && !v2_q) begin
            trow_q[k_q[4:0]] <= r1[DataW-1:0];
            acc_q <= '0;
            k_q   <= (k_q == n - 6'd1) ? '0 : k_q + 6'd1;
          end
        end
        ST_S2F: begin
          if (v2_q) acc_q <= acc_q + prod_q;
          if (!v1_q && !v2_q) begin
            out_coef_q <= r2[DataW-1:0];
            out_col_q  <= k_q[4:0];
            out_end_q  <= (k_q == n - 6'd1);
            outv_q     <= 1'b1;
            acc_q      <= '0;
          end
        end
        ST_OUT: if (!outv_q) k_q <= (k_q == n - 6'd1) ? '0 : k_q + 6'd1;
        default: ;
      endcase
      if (v1_q) prod_q <= (state_q == ST_S1 || state_q == ST_S1F) ?
                          mul16(ta_rdata, ra_rdata) : mul16(tsel_q, ta_rdata);
      tsel_q <= trow_q[m_q[4:0]];
    end
  end

  assign out_valid_o = outv_q;
  assign coeff_out_o = out_coef_q;
  assign column_o    = out_col_q;
  assign row_end_o   = out_end_q;

endmodule

// ----- rtl/hft_checker.sv -----
// ----------------------------------------------------------------------------
// hft_checker
// port-level checks of the forward transform core
// ----------------------------------------------------------------------------
module hft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       row_end_o,
  input logic [4:0] column_o
);

  // a row has started and its last item is not yet taken
  logic row_open_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_open_q <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      row_open_q <= !row_end_o;
    end
  end

  // no new item is taken while an output item is valid
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during row output");

  // a stalled result stays valid and keeps its column
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(column_o))
    else $error("result dropped while stalled");

  // first column of a row is zero
  a_first_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !row_open_q |-> column_o == 5'd0)
    else $error("row did not start at column zero");

  // rows are at least four wide
  a_end_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_end_o |-> column_o >= 5'd3)
    else $error("row ended too early");

endmodule

bind hevc_forward_transform_multisize_core hft_checker u_hft_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .row_end_o, .column_o);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the multisize forward transform core against a behavioral predictor:
// loads and row reads are streamed in under random gaps, each output item is
// compared with the oldest predicted coefficient, size changes between phases
// ----------------------------------------------------------------------------
module testbench;
  import hft_pkg::*;

  localparam int unsigned RunLimit   = 1000000;
  localparam int unsigned SettleCyc  = 64;
  localparam int unsigned DrainCyc   = 3000;
  localparam int unsigned HoldCyc    = 400;

  typedef enum logic {ITEM_DATA, ITEM_SIZE} item_kind_e;

  typedef struct {
    item_kind_e  kind;
    logic [2:0]  size_val;
    logic [1:0]  cmd;
    logic [9:0]  pos;
    logic [15:0] smp;
  } stim_item_t;

  typedef struct {
    logic signed [15:0] coeff;
    logic [4:0]         col;
    logic               last;
  } coeff_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [9:0]  position_i = '0;
  logic signed [15:0] sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] coeff_out_o;
  logic [4:0]  column_o;
  logic        row_end_o;

  hevc_forward_transform_multisize_core #(.MAX_SIZE(32)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .position_i  (position_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .coeff_out_o (coeff_out_o),
    .column_o    (column_o),
    .row_end_o   (row_end_o)
  );

  // predictor copy of the block state
  logic signed [15:0] coef_mem [1024];
  logic signed [15:0] resid_mem [1024];
  logic [2:0]         size_reg = 3'd2;

  stim_item_t  pending_q[$];
  coeff_item_t coeff_q[$];
  stim_item_t  cur_item;

  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned quiet_cnt = 0;
  int unsigned reads_seen = 0;
  int unsigned hold_cnt = 0;
  bit          hold_used = 0;
  bit          in_taken = 0;
  bit          cfg_taken = 0;
  bit          out_taken = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned loaded_n = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // size register as the block sees it: clamped to 4x4 .. 32x32
  function automatic int unsigned eff_log2(logic [2:0] v);
    if (v < 3'd2) return 2;
    if (v > 3'd5) return 5;
    return 32'(v);
  endfunction

  // compute row `row` of y = a*b*a^t and queue its n coefficients
  function automatic void predict_row(int unsigned row);
    int unsigned lg, n;
    logic signed [31:0] acc;
    logic signed [15:0] mid [32];
    coeff_item_t c;
    lg = eff_log2(size_reg);
    n  = 1 << lg;
    for (int k = 0; k < n; k++) begin
      acc = '0;
      for (int m = 0; m < n; m++)
        acc = acc + $signed(coef_mem[row*n+m]) * $signed(resid_mem[m*n+k]);
      acc = acc + (32'sd1 <<< (lg - 2));
      mid[k] = 16'(acc >>> (lg - 1));
    end
    for (int j = 0; j < n; j++) begin
      acc = '0;
      for (int k = 0; k < n; k++)
        acc = acc + $signed(mid[k]) * $signed(coef_mem[j*n+k]);
      acc = acc + (32'sd1 <<< (lg + 5));
      c.coeff = 16'(acc >>> (lg + 6));
      c.col   = j[4:0];
      c.last  = (j == n - 1);
      coeff_q.push_back(c);
    end
  endfunction

  function automatic void push_data(logic [1:0] cmd, int unsigned pos, logic [15:0] smp);
    stim_item_t it;
    it.kind = ITEM_DATA;
    it.size_val = '0;
    it.cmd = cmd;
    it.pos = pos[9:0];
    it.smp = smp;
    pending_q.push_back(it);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // one phase: size write, fill stores if this size needs unwritten entries,
  // then a random mix of loads, reads and ignored items
  function automatic void build_phase(logic [2:0] size_val, int unsigned n_rand);
    stim_item_t it;
    int unsigned n, sel;
    it.kind = ITEM_SIZE;
    it.size_val = size_val;
    it.cmd = '0;
    it.pos = '0;
    it.smp = '0;
    pending_q.push_back(it);
    n = 1 << eff_log2(size_val);
    if (n > loaded_n) begin
      for (int p = 0; p < n*n; p++) begin
        push_data(CMD_LOAD_COEF, p, rand_sample());
        push_data(CMD_LOAD_RES, p, rand_sample());
      end
      loaded_n = n;
    end
    for (int i = 0; i < n_rand; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)
        push_data($urandom_range(0, 1) ? CMD_LOAD_RES : CMD_LOAD_COEF,
                  ($urandom_range(0, 4) != 0) ? $urandom_range(0, n*n-1)
                                              : $urandom_range(0, 1023),
                  rand_sample());
      else if (sel < 85)
        push_data(CMD_READ_ROW, $urandom_range(0, n-1), 16'($urandom_range(0, 65535)));
      else if (sel < 93)
        push_data(CMD_READ_ROW, $urandom_range(0, 1023), 16'($urandom_range(0, 65535)));
      else
        push_data(2'd3, $urandom_range(0, 1023), 16'($urandom_range(0, 65535)));
    end
  endfunction

  // stimulus plan and end of run
  initial begin
    stim_item_t it;
    it.kind = ITEM_SIZE;
    it.size_val = 3'd2;
    it.cmd = '0;
    it.pos = '0;
    it.smp = '0;
    pending_q.push_back(it);
    // directed: most negative everywhere, then ignored items and far loads
    for (int p = 0; p < 16; p++) begin
      push_data(CMD_LOAD_COEF, p, 16'h8000);
      push_data(CMD_LOAD_RES, p, 16'h8000);
    end
    push_data(CMD_READ_ROW, 0, 16'h0000);
    push_data(CMD_READ_ROW, 3, 16'hffff);
    push_data(CMD_READ_ROW, 4, 16'h0000);          // row beyond block
    push_data(2'd3, 1023, 16'hffff);               // unused command
    push_data(CMD_LOAD_COEF, 1023, 16'h7fff);      // past n*n, inside store
    push_data(CMD_LOAD_RES, 1023, 16'h7fff);
    push_data(CMD_LOAD_COEF, 3, 16'h7fff);
    push_data(CMD_LOAD_RES, 12, 16'h7fff);
    push_data(CMD_READ_ROW, 3, 16'h0000);
    loaded_n = 4;
    build_phase(3'd2, 25);
    build_phase(3'd3, 10);
    build_phase(3'd0, 10);
    build_phase(3'd1, 5);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_q.size() == 0 && !in_valid_i && !cfg_valid_i && coeff_q.size() == 0);
    repeat (DrainCyc) @(posedge clk_i);
    if (coeff_q.size() != 0) begin
      $error("%0d predicted coefficients never arrived", coeff_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RunLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // accept side: update predictor state on each handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        size_reg = cfg_data_i;
        cfg_taken = 1;
      end
      if (in_valid_i && in_ready_o) begin
        in_taken = 1;
        case (command_i)
          CMD_LOAD_COEF: coef_mem[position_i] = sample_i;
          CMD_LOAD_RES:  resid_mem[position_i] = sample_i;
          CMD_READ_ROW: begin
            if (position_i < (1 << eff_log2(size_reg))) begin
              predict_row(32'(position_i));
              reads_seen++;
            end
          end
          default: ;
        endcase
      end
      // idle time since the last traffic, gates size writes
      if (coeff_q.size() == 0 && !in_valid_i)
        quiet_cnt++;
      else
        quiet_cnt = 0;
    end
  end

  // driver: one item at a time from the pending queue, random gap after each
  always @(negedge clk_i) begin
    logic nv, ncv;
    nv = in_valid_i;
    ncv = cfg_valid_i;
    if (rst_ni) begin
      if (in_taken) begin
        nv = 1'b0;
        in_taken = 0;
        send_gap = $urandom_range(0, 5);
      end
      if (cfg_taken) begin
        ncv = 1'b0;
        cfg_taken = 0;
        send_gap = $urandom_range(0, 5);
      end
      if (!nv && !ncv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].kind == ITEM_SIZE) begin
            // size only changes once every result is out and the core is idle
            if (coeff_q.size() == 0 && quiet_cnt >= SettleCyc) begin
              cur_item = pending_q.pop_front();
              cfg_data_i <= cur_item.size_val;
              ncv = 1'b1;
            end
          end else begin
            cur_item = pending_q.pop_front();
            command_i  <= cur_item.cmd;
            position_i <= cur_item.pos;
            sample_i   <= cur_item.smp;
            nv = 1'b1;
          end
        end
      end
    end
    in_valid_i  <= nv;
    cfg_valid_i <= ncv;
  end

  // long receiver hold-off once a few reads are in flight
  always @(posedge clk_i) begin
    if (!hold_used && reads_seen >= 6) begin
      hold_cnt <= HoldCyc;
      hold_used <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // receiver: random stall after each item
  always @(negedge clk_i) begin
    logic r;
    r = 1'b0;
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 0;
        recv_gap = $urandom_range(0, 5);
      end
      if (recv_gap > 0) begin
        recv_gap--;
      end else begin
        r = 1'b1;
      end
      if (hold_cnt > 0)
        r = 1'b0;
    end
    out_ready_i <= r;
  end

  // monitor: compare each output item with the oldest predicted coefficient
  always @(posedge clk_i) begin
    coeff_item_t c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_taken = 1;
      quiet_cnt = 0;
      if (coeff_q.size() == 0) begin
        $error("unexpected output item coeff %0d column %0d", coeff_out_o, column_o);
        fail_cnt++;
      end else begin
        c = coeff_q.pop_front();
        if (coeff_out_o !== c.coeff) begin
          $error("coeff_out expected %0d actual %0d", c.coeff, coeff_out_o);
          fail_cnt++;
        end
        if (column_o !== c.col) begin
          $error("column expected %0d actual %0d", c.col, column_o);
          fail_cnt++;
        end
        if (row_end_o !== c.last) begin
          $error("row_end expected %0d actual %0d", c.last, row_end_o);
          fail_cnt++;
        end
      end
    end
  end

endmodule

// ----- files.f -----
rtl/hft_pkg.sv
rtl/hft_ram.sv
rtl/hevc_forward_transform_multisize_core.sv
rtl/hft_checker.sv
verif/testbench.sv
